// ===== hw/rtl/lzbd_pkg.sv =====
// lzbd_pkg: types and constants shared by the bit-flag lz decompressor
// no dependencies
package lzbd_pkg;

  localparam int OFF_W = 14;
  localparam int LEN_W = 9;

  localparam logic [7:0]       END_BYTE  = 8'hff;
  localparam logic [OFF_W-1:0] OFF_B1    = 14'd1;
  localparam logic [OFF_W-1:0] OFF_B513  = 14'd513;
  localparam logic [OFF_W-1:0] OFF_B1025 = 14'd1025;
  localparam logic [OFF_W-1:0] OFF_B2049 = 14'd2049;
  localparam logic [OFF_W-1:0] OFF_B4097 = 14'd4097;
  localparam logic [OFF_W-1:0] OFF_SHORT = 14'd256;
  localparam logic [LEN_W-1:0] LEN_EXT   = 9'd17;
  localparam logic [LEN_W-1:0] LEN_MID   = 9'd9;

  typedef enum logic [4:0] {
    PH_TYPE, PH_KIND, PH_LIT,
    PH_LA, PH_LB, PH_LC, PH_LD, PH_LE, PH_LF, PH_LG, PH_LH, PH_LBYTE,
    PH_LEN, PH_L78, PH_LEXT, PH_LX1, PH_LX2, PH_LX3,
    PH_SSEL, PH_SBYTE1, PH_SP, PH_SQ, PH_SR, PH_SBYTE2
  } ph_t;

  typedef enum logic [1:0] {P_IDLE, P_BITS, P_WAIT} pst_t;
  typedef enum logic [1:0] {C_IDLE, C_RD, C_WR, C_END} cst_t;
  typedef enum logic [1:0] {J_LIT, J_COPY, J_END} jk_t;

  typedef struct packed {
    logic             vld;
    logic             clr;
    jk_t              kind;
    logic [7:0]       lit;
    logic [OFF_W-1:0] off;
    logic [LEN_W-1:0] len;
  } job_t;

  function automatic logic is_byte_ph(ph_t p);
    return (p == PH_LIT) || (p == PH_LBYTE) || (p == PH_LEXT) ||
           (p == PH_SBYTE1) || (p == PH_SBYTE2);
  endfunction

endpackage

// ===== hw/rtl/lzbd_in_if.sv =====
// lzbd_in_if: compressed byte channel, valid/ready
// no dependencies
interface lzbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_start;
  modport source (output valid, in_byte, stream_start, input ready);
  modport sink (input valid, in_byte, stream_start, output ready);
endinterface

// ===== hw/rtl/lzbd_out_if.sv =====
// lzbd_out_if: decoded result channel, valid/ready
// no dependencies
interface lzbd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] out_data;
  logic [3:0]  out_count;
  logic        run_last;
  logic        stream_end;
  modport source (output valid, out_data, out_count, run_last, stream_end, input ready);
  modport sink (input valid, out_data, out_count, run_last, stream_end, output ready);
endinterface

// ===== hw/rtl/lzbd_ram.sv =====
// lzbd_ram: generic single-port-write, single-port-read ram, registered read
// no dependencies
module lzbd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         q_r
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      q_r <= mem[raddr];
    end
  end
endmodule

// ===== hw/rtl/lzbd_parser.sv =====
// lzbd_parser: flag word and code parser, issues literal/copy/end jobs
// depends on lzbd_pkg, lzbd_in_if
module lzbd_parser
  import lzbd_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  lzbd_in_if.sink in_ch,
  input  logic  done,
  output job_t  job_r
);
  pst_t st_r, st_nxt;
  ph_t  ph_r, ph_nxt;
  logic [15:0]      fb_r, fb_nxt;
  logic [4:0]       fl_r, fl_nxt;
  logic [7:0]       lo_r, lo_nxt;
  logic             held_r, held_nxt;
  logic [OFF_W-1:0] mo_r, mo_nxt;
  logic [3:0]       oh_r, oh_nxt;
  logic [LEN_W-1:0] ml_r, ml_nxt;
  logic             end_r, end_nxt;
  job_t             job_nxt;

  logic             acc, rs, b;
  logic [7:0]       v;
  ph_t              c_ph, d_ph;
  logic [15:0]      c_fb;
  logic [4:0]       c_fl;
  logic             c_held, c_end;
  logic [OFF_W-1:0] c_mo, d_mo;
  logic [3:0]       c_oh, d_oh;
  logic [LEN_W-1:0] c_ml, d_ml;
  logic             d_end, d_job;
  jk_t              d_kind;
  logic [OFF_W-1:0] d_off;
  logic [LEN_W-1:0] d_len;

  assign in_ch.ready = (st_r == P_IDLE);
  assign acc = in_ch.valid && (st_r == P_IDLE);
  assign rs  = acc && in_ch.stream_start;
  assign v   = in_ch.in_byte;
  assign b   = fb_r[0];

  // state as seen by this beat, with a stream start applied
  always_comb begin
    c_ph   = rs ? PH_TYPE : ph_r;
    c_fb   = rs ? 16'd0 : fb_r;
    c_fl   = rs ? 5'd0 : fl_r;
    c_held = rs ? 1'b0 : held_r;
    c_end  = rs ? 1'b0 : end_r;
    c_mo   = rs ? '0 : mo_r;
    c_oh   = rs ? 4'd0 : oh_r;
    c_ml   = rs ? '0 : ml_r;
  end

  // code decode: byte phases use the input byte, others the next flag bit
  always_comb begin
    d_ph   = c_ph;
    d_mo   = c_mo;
    d_oh   = c_oh;
    d_ml   = c_ml;
    d_end  = 1'b0;
    d_job  = 1'b0;
    d_kind = J_COPY;
    d_off  = c_mo;
    d_len  = c_ml;
    case (c_ph)
      PH_TYPE: d_ph = b ? PH_LIT : PH_KIND;
      PH_KIND: d_ph = b ? PH_LA : PH_SSEL;
      PH_LIT: begin
        d_job  = 1'b1;
        d_kind = J_LIT;
        d_ph   = PH_TYPE;
      end
      PH_LA: begin
        d_oh = {3'd0, b};
        d_ph = PH_LB;
      end
      PH_LB: begin
        if (b) begin
          d_mo = OFF_B1;
          d_ph = PH_LBYTE;
        end else begin
          d_ph = PH_LC;
        end
      end
      PH_LC: begin
        if (b) begin
          d_mo = OFF_B513;
          d_ph = PH_LBYTE;
        end else begin
          d_ph = PH_LD;
        end
      end
      PH_LD: begin
        d_oh = {c_oh[2:0], b};
        d_ph = PH_LE;
      end
      PH_LE: begin
        if (b) begin
          d_mo = OFF_B1025;
          d_ph = PH_LBYTE;
        end else begin
          d_ph = PH_LF;
        end
      end
      PH_LF: begin
        d_oh = {c_oh[2:0], b};
        d_ph = PH_LG;
      end
      PH_LG: begin
        if (b) begin
          d_mo = OFF_B2049;
          d_ph = PH_LBYTE;
        end else begin
          d_ph = PH_LH;
        end
      end
      PH_LH: begin
        d_oh = {c_oh[2:0], b};
        d_mo = OFF_B4097;
        d_ph = PH_LBYTE;
      end
      PH_LBYTE: begin
        d_mo = c_mo + {2'd0, c_oh, v};
        d_ml = '0;
        d_ph = PH_LEN;
      end
      PH_LEN: begin
        if (b) begin
          if (c_ml < LEN_W'(4)) begin
            d_ml  = c_ml + LEN_W'(3);
            d_len = c_ml + LEN_W'(3);
            d_job = 1'b1;
            d_ph  = PH_TYPE;
          end else if (c_ml == LEN_W'(4)) begin
            d_ph = PH_L78;
          end else begin
            d_ph = PH_LEXT;
          end
        end else if (c_ml < LEN_W'(5)) begin
          d_ml = c_ml + LEN_W'(1);
        end else begin
          d_ml = '0;
          d_ph = PH_LX1;
        end
      end
      PH_L78: begin
        d_ml  = b ? LEN_W'(8) : LEN_W'(7);
        d_len = d_ml;
        d_job = 1'b1;
        d_ph  = PH_TYPE;
      end
      PH_LX1: begin
        d_ml = {{(LEN_W-3){1'b0}}, b, 2'b00};
        d_ph = PH_LX2;
      end
      PH_LX2: begin
        d_ml = c_ml | {{(LEN_W-2){1'b0}}, b, 1'b0};
        d_ph = PH_LX3;
      end
      PH_LX3: begin
        d_ml  = (c_ml | {{(LEN_W-1){1'b0}}, b}) + LEN_MID;
        d_len = d_ml;
        d_job = 1'b1;
        d_ph  = PH_TYPE;
      end
      PH_LEXT: begin
        d_ml  = {1'b0, v} + LEN_EXT;
        d_len = d_ml;
        d_job = 1'b1;
        d_ph  = PH_TYPE;
      end
      PH_SSEL: d_ph = b ? PH_SP : PH_SBYTE1;
      PH_SBYTE1: begin
        d_ph = PH_TYPE;
        if (v == END_BYTE) begin
          d_end  = 1'b1;
          d_job  = 1'b1;
          d_kind = J_END;
        end else begin
          d_mo  = {6'd0, v} + OFF_B1;
          d_off = d_mo;
          d_ml  = LEN_W'(2);
          d_len = d_ml;
          d_job = 1'b1;
        end
      end
      PH_SP: begin
        d_mo = {3'd0, b, 10'd0};
        d_ph = PH_SQ;
      end
      PH_SQ: begin
        d_mo = c_mo | {4'd0, b, 9'd0};
        d_ph = PH_SR;
      end
      PH_SR: begin
        d_mo = c_mo | {5'd0, b, 8'd0};
        d_ph = PH_SBYTE2;
      end
      PH_SBYTE2: begin
        d_mo  = (c_mo | {6'd0, v}) + OFF_SHORT;
        d_off = d_mo;
        d_ml  = LEN_W'(2);
        d_len = d_ml;
        d_job = 1'b1;
        d_ph  = PH_TYPE;
      end
      default: d_ph = PH_TYPE;
    endcase
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      P_IDLE: begin
        if (acc && !c_end) begin
          if (is_byte_ph(c_ph)) begin
            st_nxt = d_job ? P_WAIT : P_BITS;
          end else if (c_held) begin
            st_nxt = P_BITS;
          end
        end
      end
      P_BITS: begin
        if (end_r || fl_r == 5'd0 || is_byte_ph(ph_r)) begin
          st_nxt = P_IDLE;
        end else if (d_job) begin
          st_nxt = P_WAIT;
        end
      end
      P_WAIT: begin
        if (done) begin
          st_nxt = P_BITS;
        end
      end
      default: st_nxt = P_IDLE;
    endcase
  end

  // parser registers and job issue
  always_comb begin
    ph_nxt   = ph_r;
    fb_nxt   = fb_r;
    fl_nxt   = fl_r;
    lo_nxt   = lo_r;
    held_nxt = held_r;
    mo_nxt   = mo_r;
    oh_nxt   = oh_r;
    ml_nxt   = ml_r;
    end_nxt  = end_r;
    job_nxt  = '0;
    job_nxt.kind = J_COPY;
    case (st_r)
      P_IDLE: begin
        if (acc) begin
          ph_nxt      = c_ph;
          fb_nxt      = c_fb;
          fl_nxt      = c_fl;
          held_nxt    = c_held;
          end_nxt     = c_end;
          mo_nxt      = c_mo;
          oh_nxt      = c_oh;
          ml_nxt      = c_ml;
          job_nxt.clr = rs;
          if (!c_end) begin
            if (is_byte_ph(c_ph)) begin
              ph_nxt       = d_ph;
              mo_nxt       = d_mo;
              oh_nxt       = d_oh;
              ml_nxt       = d_ml;
              end_nxt      = d_end;
              job_nxt.vld  = d_job;
              job_nxt.kind = d_kind;
              job_nxt.lit  = v;
              job_nxt.off  = d_off;
              job_nxt.len  = d_len;
            end else if (!c_held) begin
              lo_nxt   = v;
              held_nxt = 1'b1;
            end else begin
              fb_nxt   = {v, lo_r};
              fl_nxt   = 5'd16;
              held_nxt = 1'b0;
            end
          end
        end
      end
      P_BITS: begin
        if (!(end_r || fl_r == 5'd0 || is_byte_ph(ph_r))) begin
          fb_nxt       = {1'b0, fb_r[15:1]};
          fl_nxt       = fl_r - 5'd1;
          ph_nxt       = d_ph;
          mo_nxt       = d_mo;
          oh_nxt       = d_oh;
          ml_nxt       = d_ml;
          job_nxt.vld  = d_job;
          job_nxt.kind = d_kind;
          job_nxt.off  = d_off;
          job_nxt.len  = d_len;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= P_IDLE;
      ph_r   <= PH_TYPE;
      fb_r   <= '0;
      fl_r   <= '0;
      lo_r   <= '0;
      held_r <= 1'b0;
      mo_r   <= '0;
      oh_r   <= '0;
      ml_r   <= '0;
      end_r  <= 1'b0;
      job_r  <= '0;
    end else begin
      st_r   <= st_nxt;
      ph_r   <= ph_nxt;
      fb_r   <= fb_nxt;
      fl_r   <= fl_nxt;
      lo_r   <= lo_nxt;
      held_r <= held_nxt;
      mo_r   <= mo_nxt;
      oh_r   <= oh_nxt;
      ml_r   <= ml_nxt;
      end_r  <= end_nxt;
      job_r  <= job_nxt;
    end
  end
endmodule

// ===== hw/rtl/lzbd_copy.sv =====
// lzbd_copy: history memory, byte copy engine, result packing and output register
// depends on lzbd_pkg, lzbd_ram, lzbd_out_if
module lzbd_copy
  import lzbd_pkg::*;
#(
  parameter int HISTORY_DEPTH    = 8192,
  parameter int BYTES_PER_RESULT = 8
) (
  input  logic clk,
  input  logic rst_n,
  input  job_t job,
  output logic done,
  lzbd_out_if.source out_ch
);
  localparam int AW = $clog2(HISTORY_DEPTH);
  localparam int CW = AW + 1;
  localparam logic [AW-1:0] WP_MAX = AW'(HISTORY_DEPTH - 1);
  localparam logic [3:0]    PK_TOP = 4'(BYTES_PER_RESULT - 1);

  cst_t st_r, st_nxt;
  logic [AW-1:0]    wp_r, wp_nxt;
  logic             wrap_r, wrap_nxt;
  logic [OFF_W-1:0] off_r, off_nxt;
  logic [LEN_W-1:0] rem_r, rem_nxt;
  logic [7:0]       lit_r, lit_nxt;
  logic             islit_r, islit_nxt;
  logic             zero_r, zero_nxt;
  logic [7:0]       pk_r [BYTES_PER_RESULT];
  logic [7:0]       pk_nxt [BYTES_PER_RESULT];
  logic [3:0]       pkc_r, pkc_nxt;
  logic             o_vld_r, o_vld_nxt;
  logic [63:0]      o_data_r, o_data_nxt;
  logic [3:0]       o_cnt_r, o_cnt_nxt;
  logic             o_last_r, o_last_nxt;
  logic             o_end_r, o_end_nxt;

  logic [CW-1:0] wp_e, off_e, rd_sum;
  logic [AW-1:0] raddr;
  logic [7:0]    ram_q, byte_w;
  logic          out_free, last, push, stall, we;

  assign out_free = !o_vld_r || out_ch.ready;
  assign wp_e     = CW'(wp_r);
  assign off_e    = CW'(off_r);
  assign rd_sum   = (wp_e >= off_e) ? (wp_e - off_e) : (wp_e + CW'(HISTORY_DEPTH) - off_e);
  assign raddr    = rd_sum[AW-1:0];
  // entries not written since the stream start read as zero
  assign byte_w   = islit_r ? lit_r : (zero_r ? 8'h00 : ram_q);
  assign last     = (rem_r == LEN_W'(1));
  assign push     = last || (pkc_r == PK_TOP);
  assign stall    = push && !out_free;
  assign we       = (st_r == C_WR) && !stall;
  assign done     = ((st_r == C_WR) && !stall && last) || ((st_r == C_END) && out_free);

  lzbd_ram #(
    .WIDTH(8),
    .DEPTH(HISTORY_DEPTH)
  ) u_hist (
    .clk  (clk),
    .we   (we),
    .waddr(wp_r),
    .wdata(byte_w),
    .re   (st_r == C_RD),
    .raddr(raddr),
    .q_r  (ram_q)
  );

  assign out_ch.valid      = o_vld_r;
  assign out_ch.out_data   = o_data_r;
  assign out_ch.out_count  = o_cnt_r;
  assign out_ch.run_last   = o_last_r;
  assign out_ch.stream_end = o_end_r;

  // next state
  always_comb begin
    st_nxt = st_r;
    case (st_r)
      C_IDLE: begin
        if (job.vld) begin
          case (job.kind)
            J_LIT:   st_nxt = C_WR;
            J_COPY:  st_nxt = C_RD;
            J_END:   st_nxt = C_END;
            default: st_nxt = C_IDLE;
          endcase
        end
      end
      C_RD: st_nxt = C_WR;
      C_WR: begin
        if (!stall) begin
          st_nxt = last ? C_IDLE : C_RD;
        end
      end
      C_END: begin
        if (out_free) begin
          st_nxt = C_IDLE;
        end
      end
      default: st_nxt = C_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    wp_nxt     = wp_r;
    wrap_nxt   = wrap_r;
    off_nxt    = off_r;
    rem_nxt    = rem_r;
    lit_nxt    = lit_r;
    islit_nxt  = islit_r;
    zero_nxt   = zero_r;
    pk_nxt     = pk_r;
    pkc_nxt    = pkc_r;
    o_vld_nxt  = o_vld_r && !out_ch.ready;
    o_data_nxt = o_data_r;
    o_cnt_nxt  = o_cnt_r;
    o_last_nxt = o_last_r;
    o_end_nxt  = o_end_r;
    case (st_r)
      C_IDLE: begin
        if (job.clr) begin
          wp_nxt   = '0;
          wrap_nxt = 1'b0;
        end
        if (job.vld) begin
          islit_nxt = (job.kind == J_LIT);
          lit_nxt   = job.lit;
          off_nxt   = job.off;
          rem_nxt   = (job.kind == J_LIT) ? LEN_W'(1) : job.len;
        end
      end
      C_RD: zero_nxt = !wrap_r && (off_e > wp_e);
      C_WR: begin
        if (!stall) begin
          wp_nxt  = (wp_r == WP_MAX) ? '0 : wp_r + AW'(1);
          rem_nxt = rem_r - LEN_W'(1);
          if (wp_r == WP_MAX) begin
            wrap_nxt = 1'b1;
          end
          if (push) begin
            o_vld_nxt  = 1'b1;
            o_data_nxt = '0;
            for (int j = 0; j < 8; j++) begin
              if (j < BYTES_PER_RESULT) begin
                o_data_nxt[8*j +: 8] = (4'(j) == pkc_r) ? byte_w : pk_r[j];
              end
            end
            o_cnt_nxt  = pkc_r + 4'd1;
            o_last_nxt = last;
            o_end_nxt  = 1'b0;
            for (int j = 0; j < BYTES_PER_RESULT; j++) begin
              pk_nxt[j] = 8'h00;
            end
            pkc_nxt = 4'd0;
          end else begin
            for (int j = 0; j < BYTES_PER_RESULT; j++) begin
              if (4'(j) == pkc_r) begin
                pk_nxt[j] = byte_w;
              end
            end
            pkc_nxt = pkc_r + 4'd1;
          end
        end
      end
      C_END: begin
        if (out_free) begin
          o_vld_nxt  = 1'b1;
          o_data_nxt = '0;
          o_cnt_nxt  = 4'd0;
          o_last_nxt = 1'b1;
          o_end_nxt  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= C_IDLE;
      wp_r    <= '0;
      wrap_r  <= 1'b0;
      pkc_r   <= 4'd0;
      o_vld_r <= 1'b0;
      for (int j = 0; j < BYTES_PER_RESULT; j++) begin
        pk_r[j] <= 8'h00;
      end
    end else begin
      st_r    <= st_nxt;
      wp_r    <= wp_nxt;
      wrap_r  <= wrap_nxt;
      pkc_r   <= pkc_nxt;
      o_vld_r <= o_vld_nxt;
      pk_r    <= pk_nxt;
    end
  end

  always_ff @(posedge clk) begin
    off_r    <= off_nxt;
    rem_r    <= rem_nxt;
    lit_r    <= lit_nxt;
    islit_r  <= islit_nxt;
    zero_r   <= zero_nxt;
    o_data_r <= o_data_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_last_r <= o_last_nxt;
    o_end_r  <= o_end_nxt;
  end
endmodule

// ===== hw/rtl/lz_bitflag_decompressor.sv =====
// lz_bitflag_decompressor: top level of the bit-flag lz77 stream decoder
// depends on lzbd_pkg, lzbd_in_if, lzbd_out_if, lzbd_parser, lzbd_copy
//
// Takes one compressed byte per beat and returns results of up to
// BYTES_PER_RESULT decoded bytes, the last result of each literal or copy
// flagged run_last. A beat is first accepted; a flag word beat or a code
// byte beat then walks the flag bits left in the current word one by one,
// and a last step closes the bit walk. Each literal or match is handed to
// the copy engine as a registered job, and the parser waits until the
// engine is done with it. The engine writes a literal straight away and
// copies each match byte as a read then a write of the single history ram;
// a match is at most 272 bytes. Reads older than the stream start return
// zero through a wrap flag on the write position, so no clearing pass is
// needed after reset or stream_start. Results wait in one output register;
// a stalled output holds the copy engine.
module lz_bitflag_decompressor
  import lzbd_pkg::*;
#(
  parameter int HISTORY_DEPTH    = 8192,
  parameter int BYTES_PER_RESULT = 8
) (
  input  logic clk,
  input  logic rst_n,
  lzbd_in_if.sink    in_ch,
  lzbd_out_if.source out_ch
);
  job_t job;
  logic done;

  lzbd_parser u_parser (
    .clk  (clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .done (done),
    .job_r(job)
  );

  lzbd_copy #(
    .HISTORY_DEPTH   (HISTORY_DEPTH),
    .BYTES_PER_RESULT(BYTES_PER_RESULT)
  ) u_copy (
    .clk   (clk),
    .rst_n (rst_n),
    .job   (job),
    .done  (done),
    .out_ch(out_ch)
  );
endmodule

// ===== bench/lz_bitflag_decompressor_tb.sv =====
// lz_bitflag_decompressor_tb: self-checking bench for the bit-flag lz77 stream decoder
// builds well-formed compressed streams plus noise, predicts decoded beats in a scoreboard
// depends on lzbd_pkg, lzbd_in_if, lzbd_out_if and lz_bitflag_decompressor
module lz_bitflag_decompressor_tb;
  import lzbd_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int HIST_DEPTH = 8192;
  localparam int COPY_CAP   = 272;
  localparam int WATCHDOG   = 5000;

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic        last;
    logic        fin;
  } beat_t;

  typedef struct packed {
    logic [7:0] b;
    logic       start;
  } code_byte_t;

  class decode_scoreboard;
    ph_t        phase;
    logic [15:0] flags;
    int          flags_left;
    logic [7:0]  low_byte;
    bit          low_held;
    logic [13:0] moff;
    logic [3:0]  hi_bits;
    logic [8:0]  mlen;
    logic [7:0]  hist [HIST_DEPTH];
    logic [12:0] wpos;
    bit          ended;
    logic [7:0]  decoded [$];
    beat_t       beats_due [$];
    int          fails;

    function void clear_stream();
      phase = PH_TYPE;
      flags = '0;
      flags_left = 0;
      low_byte = '0;
      low_held = 0;
      moff = '0;
      hi_bits = '0;
      mlen = '0;
      foreach (hist[i]) hist[i] = '0;
      wpos = '0;
      ended = 0;
    endfunction

    function int pending();
      return beats_due.size();
    endfunction

    function bit at_byte(ph_t p);
      return p == PH_LIT || p == PH_LBYTE || p == PH_LEXT || p == PH_SBYTE1 || p == PH_SBYTE2;
    endfunction

    function void put_out(logic [7:0] b);
      hist[wpos] = b;
      wpos = wpos + 1'b1;
      decoded.push_back(b);
    endfunction

    function void run_copy();
      int off;
      off = moff % (HIST_DEPTH + 1);
      for (int i = 0; i < mlen && i < COPY_CAP; i++)
        put_out(hist[(int'(wpos) + HIST_DEPTH - off) % HIST_DEPTH]);
      phase = PH_TYPE;
    endfunction

    function void eat_bit(logic b);
      case (phase)
        PH_TYPE: phase = b ? PH_LIT : PH_KIND;
        PH_KIND: phase = b ? PH_LA : PH_SSEL;
        PH_LA: begin hi_bits = {3'b0, b}; phase = PH_LB; end
        PH_LB: if (b) begin moff = OFF_B1; phase = PH_LBYTE; end else phase = PH_LC;
        PH_LC: if (b) begin moff = OFF_B513; phase = PH_LBYTE; end else phase = PH_LD;
        PH_LD: begin hi_bits = {hi_bits[2:0], b}; phase = PH_LE; end
        PH_LE: if (b) begin moff = OFF_B1025; phase = PH_LBYTE; end else phase = PH_LF;
        PH_LF: begin hi_bits = {hi_bits[2:0], b}; phase = PH_LG; end
        PH_LG: if (b) begin moff = OFF_B2049; phase = PH_LBYTE; end else phase = PH_LH;
        PH_LH: begin
          hi_bits = {hi_bits[2:0], b};
          moff = OFF_B4097;
          phase = PH_LBYTE;
        end
        PH_LEN: begin
          if (b) begin
            if (mlen < 4) begin
              mlen = mlen + 9'd3;
              run_copy();
            end else if (mlen == 4) phase = PH_L78;
            else phase = PH_LEXT;
          end else if (mlen < 5) begin
            mlen = mlen + 9'd1;
          end else begin
            mlen = '0;
            phase = PH_LX1;
          end
        end
        PH_L78: begin mlen = b ? 9'd8 : 9'd7; run_copy(); end
        PH_LX1: begin mlen = {6'b0, b, 2'b0}; phase = PH_LX2; end
        PH_LX2: begin mlen[1] = b; phase = PH_LX3; end
        PH_LX3: begin mlen = {mlen[8:1], b} + LEN_MID; run_copy(); end
        PH_SSEL: phase = b ? PH_SP : PH_SBYTE1;
        PH_SP: begin moff = {3'b0, b, 10'b0}; phase = PH_SQ; end
        PH_SQ: begin moff[9] = b; phase = PH_SR; end
        PH_SR: begin moff[8] = b; phase = PH_SBYTE2; end
        default: phase = PH_TYPE;
      endcase
    endfunction

    function void eat_byte(logic [7:0] v);
      case (phase)
        PH_LIT: begin put_out(v); phase = PH_TYPE; end
        PH_LBYTE: begin
          moff = moff + {2'b0, hi_bits, v};
          mlen = '0;
          phase = PH_LEN;
        end
        PH_LEXT: begin mlen = {1'b0, v} + LEN_EXT; run_copy(); end
        PH_SBYTE1: begin
          if (v == END_BYTE) begin
            ended = 1;
            phase = PH_TYPE;
          end else begin
            moff = {6'b0, v} + 14'd1;
            mlen = 9'd2;
            run_copy();
          end
        end
        PH_SBYTE2: begin
          moff = {moff[13:8], v} + OFF_SHORT;
          mlen = 9'd2;
          run_copy();
        end
        default: phase = PH_TYPE;
      endcase
    endfunction

    function void note_input(logic [7:0] v, logic start);
      int nbeats;
      beat_t r;
      if (start) clear_stream();
      if (ended) return;
      decoded.delete();
      if (at_byte(phase)) begin
        eat_byte(v);
      end else if (!low_held) begin
        low_byte = v;
        low_held = 1;
        return;
      end else begin
        flags = {v, low_byte};
        flags_left = 16;
        low_held = 0;
      end
      while (!ended && flags_left > 0 && !at_byte(phase)) begin
        logic b;
        b = flags[0];
        flags = flags >> 1;
        flags_left--;
        eat_bit(b);
      end
      if (ended) begin
        beats_due.push_back('{data: '0, count: '0, last: 1'b1, fin: 1'b1});
        return;
      end
      nbeats = (decoded.size() + 7) / 8;
      for (int k = 0; k < nbeats; k++) begin
        r = '0;
        for (int j = 0; j < 8 && k * 8 + j < decoded.size(); j++) begin
          r.data[8*j +: 8] = decoded[k * 8 + j];
          r.count++;
        end
        r.last = (k + 1 == nbeats);
        beats_due.push_back(r);
      end
    endfunction

    function void check(beat_t got);
      beat_t want;
      if (beats_due.size() == 0) begin
        $display("%0t: unexpected beat data=%h count=%0d last=%b end=%b", $time,
                 got.data, got.count, got.last, got.fin);
        fails++;
        return;
      end
      want = beats_due.pop_front();
      if (got.data !== want.data) begin
        $display("%0t: out_data expected %h actual %h", $time, want.data, got.data);
        fails++;
      end
      if (got.count !== want.count) begin
        $display("%0t: out_count expected %0d actual %0d", $time, want.count, got.count);
        fails++;
      end
      if (got.last !== want.last) begin
        $display("%0t: run_last expected %b actual %b", $time, want.last, got.last);
        fails++;
      end
      if (got.fin !== want.fin) begin
        $display("%0t: stream_end expected %b actual %b", $time, want.fin, got.fin);
        fails++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  lzbd_in_if  in_ch ();
  lzbd_out_if out_ch ();

  lz_bitflag_decompressor uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  decode_scoreboard sb = new();
  code_byte_t stream_q [$];
  int  flag_slot;
  int  bits_free;
  bit  first_byte;
  bit  quiet;
  int  stall_left;
  int  idle_cycles;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom % 16;
    if (r < 9) return 0;
    if (r < 14) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic push_code_byte(logic [7:0] v);
    stream_q.push_back('{b: v, start: first_byte});
    first_byte = 0;
  endtask

  task automatic put_bit(logic b);
    int pos;
    if (bits_free == 0) begin
      flag_slot = stream_q.size();
      push_code_byte(8'h00);
      push_code_byte(8'h00);
      bits_free = 16;
    end
    pos = 16 - bits_free;
    stream_q[flag_slot + pos / 8].b[pos % 8] = b;
    bits_free--;
  endtask

  task automatic begin_stream();
    first_byte = 1;
    bits_free = 0;
  endtask

  task automatic code_lit(logic [7:0] v);
    put_bit(1);
    push_code_byte(v);
  endtask

  task automatic code_long(int cls, logic [3:0] hb, logic [7:0] ob, int lz, logic [7:0] lx);
    put_bit(0);
    put_bit(1);
    put_bit(hb[0]);
    case (cls)
      0: put_bit(1);
      1: begin put_bit(0); put_bit(1); end
      2: begin put_bit(0); put_bit(0); put_bit(hb[1]); put_bit(1); end
      3: begin
        put_bit(0); put_bit(0); put_bit(hb[1]); put_bit(0); put_bit(hb[2]); put_bit(1);
      end
      default: begin
        put_bit(0); put_bit(0); put_bit(hb[1]); put_bit(0); put_bit(hb[2]); put_bit(0);
        put_bit(hb[3]);
      end
    endcase
    push_code_byte(ob);
    for (int i = 0; i < (lz > 5 ? 6 : lz); i++) put_bit(0);
    if (lz <= 3) put_bit(1);
    else if (lz == 4) begin put_bit(1); put_bit(lx[0]); end
    else if (lz == 5) begin put_bit(1); push_code_byte(lx); end
    else begin put_bit(lx[2]); put_bit(lx[1]); put_bit(lx[0]); end
  endtask

  task automatic code_short(logic sel, logic [2:0] sbits, logic [7:0] v);
    put_bit(0);
    put_bit(0);
    put_bit(sel);
    if (sel) begin put_bit(sbits[2]); put_bit(sbits[1]); put_bit(sbits[0]); end
    push_code_byte(v);
  endtask

  task automatic random_code();
    int r;
    logic [7:0] lx;
    r = $urandom % 10;
    lx = ($urandom % 6 == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
    if (r < 4) code_lit(8'($urandom));
    else if (r < 7)
      code_long($urandom_range(0, 4), 4'($urandom), 8'($urandom), $urandom_range(0, 6), lx);
    else code_short(1'($urandom), 3'($urandom), 8'($urandom_range(0, 254)));
  endtask

  task automatic send_all();
    code_byte_t it;
    while (stream_q.size() > 0) begin
      int g;
      it = stream_q.pop_front();
      g = pick_gap();
      if (g > 0) begin
        in_ch.valid = 0;
        repeat (g) @(negedge clk);
      end
      in_ch.in_byte = it.b;
      in_ch.stream_start = it.start;
      in_ch.valid = 1;
      @(posedge clk);
      while (!in_ch.ready) @(posedge clk);
      sb.note_input(it.b, it.start);
      @(negedge clk);
    end
    in_ch.valid = 0;
  endtask

  always @(negedge clk) begin
    if (rst_n) begin
      if (stall_left > 0) begin
        out_ch.ready = 0;
        stall_left--;
      end else begin
        out_ch.ready = 1;
        if ($urandom % 6 == 0) stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check('{data: out_ch.out_data, count: out_ch.out_count,
                 last: out_ch.run_last, fin: out_ch.stream_end});
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !rst_n)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int sent_target;
    rst_n = 0;
    in_ch.valid = 0;
    in_ch.in_byte = '0;
    in_ch.stream_start = 0;
    out_ch.ready = 0;
    stall_left = 0;
    idle_cycles = 0;
    quiet = 0;
    sb.clear_stream();
    sb.fails = 0;
    repeat (10) @(negedge clk);
    rst_n = 1;

    // directed: extremes, every offset class and length form, end code
    begin_stream();
    code_lit(8'h00);
    code_lit(8'hff);
    code_short(0, 3'b000, 8'h00);
    code_short(1, 3'b111, 8'hfe);
    code_long(0, 4'hf, 8'hff, 0, 8'h00);
    code_long(1, 4'h0, 8'h00, 3, 8'h00);
    code_long(2, 4'h5, 8'h80, 4, 8'h01);
    code_long(3, 4'ha, 8'h7f, 6, 8'h07);
    code_long(4, 4'hf, 8'hff, 5, 8'hff);
    code_long(4, 4'h0, 8'h00, 6, 8'h00);
    code_short(0, 3'b000, END_BYTE);
    push_code_byte(8'h5a);
    push_code_byte(8'ha5);
    send_all();
    // hold the sender until every beat is back
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);

    sent_target = 320;
    while (sent_target > 0) begin
      int ncodes;
      quiet = ($urandom % 4 == 0);
      begin_stream();
      if ($urandom % 8 == 0) begin
        for (int i = 0; i < 10; i++) push_code_byte(8'($urandom));
      end else begin
        ncodes = $urandom_range(3, 18);
        for (int i = 0; i < ncodes; i++) random_code();
        if ($urandom % 4 != 0) begin
          code_short(0, 3'b000, END_BYTE);
          repeat ($urandom_range(0, 3)) push_code_byte(8'($urandom));
        end
      end
      sent_target -= stream_q.size();
      send_all();
    end

    while (sb.pending() != 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (sb.fails == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
